>>> sv/mcts_child_scan_ucb1_solver_core_assert.svh
// Assertion macros shared by the child scan RTL modules.
// Expects signals named clk and arst_n in the including module.
`ifndef MCTS_CHILD_SCAN_UCB1_SOLVER_CORE_ASSERT_SVH
`define MCTS_CHILD_SCAN_UCB1_SOLVER_CORE_ASSERT_SVH

// same-cycle implication
`define MCCS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MCCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/mccs_pkg.sv
// Shared types, constants and helpers for the child scan / UCB1 / solver core.
// No dependencies; used by every module of the block.
package mccs_pkg;

	localparam int MAX_CHILDREN = 64;
	localparam int CNT_W        = $clog2(MAX_CHILDREN + 1);
	localparam int POS_W        = 6;

	localparam int N_W     = 32;
	localparam int WIN_W   = 48;
	localparam int GAIN_W  = 16;
	localparam int LOG_W   = 21;  // ln(N) in Q16.16, below 2^21
	localparam int T_W     = LOG_W + 1;
	localparam int SQ_IN_W = T_W + 16;
	localparam int SQ_STEPS = SQ_IN_W / 2;
	localparam int SQ_OUT_W = SQ_STEPS;
	localparam int U_W     = GAIN_W + SQ_OUT_W - 8;

	localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd362;
	localparam logic [15:0]        LN2_Q16    = 16'd45426;
	localparam logic [13:0]        PROOF_BASE = 14'd10000;
	localparam logic [5:0]         DIV_Q_STEPS = 6'd48;
	localparam logic [5:0]         DIV_T_STEPS = 6'(T_W);
	localparam logic [4:0]         LOG_SQ_STEPS = 5'd16;
	localparam logic [SQ_IN_W-1:0] SQ_BIT0 = SQ_IN_W'(1) << (2 * (SQ_STEPS - 1));
	localparam logic signed [17:0] RATE_MAX  = 18'sd131071;
	localparam logic signed [17:0] RATE_NONE = -18'sd65536;

	typedef enum logic [1:0] {
		PROOF_UNKNOWN = 2'd0,
		PROOF_WIN     = 2'd1,
		PROOF_LOSS    = 2'd2,
		PROOF_DRAW    = 2'd3
	} proof_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_LOG_INIT,
		S_LOG_NORM,
		S_LOG_SQ,
		S_LOG_FIN,
		S_DIV_Q_GO,
		S_DIV_Q_WAIT,
		S_DIV_T_GO,
		S_DIV_T_WAIT,
		S_SQRT_GO,
		S_SQRT_WAIT,
		S_MUL_U,
		S_UPDATE,
		S_EMIT,
		S_EMIT_EMPTY
	} ctrl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic log_init;
		logic log_norm;
		logic log_sq;
		logic log_fin;
		logic div_q_go;
		logic div_t_go;
		logic sqrt_go;
		logic mul_u;
		logic update;
		logic emit_node;
		logic emit_empty;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic last;
		logic skip;
		logic first;
		logic x_norm;
		logic sq_done;
		logic div_done;
		logic sqrt_done;
		logic out_free;
	} stat_t;

	// proof depth plus one, saturating at 255
	function automatic logic [7:0] depth_inc(input logic [7:0] d);
		return (d < 8'd254) ? d + 8'd1 : 8'd255;
	endfunction

endpackage

>>> sv/mccs_div.sv
// Restoring divider, one quotient bit per cycle, variable step count.
// Depends on mccs_pkg for widths.
module mccs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mccs_pkg::WIN_W-1:0]    dividend,
	input  logic [mccs_pkg::N_W-1:0]      divisor,
	input  logic [5:0]                    steps,
	output logic                          done,
	output logic [mccs_pkg::WIN_W-1:0]    quotient
);

	logic [mccs_pkg::WIN_W-1:0] a_q;
	logic [mccs_pkg::N_W-1:0]   r_q;
	logic [mccs_pkg::N_W-1:0]   d_q;
	logic [5:0]                 cnt_q;
	logic [5:0]                 steps_q;
	logic                       busy_q;
	logic                       done_q;
	logic [mccs_pkg::N_W:0]     r_sh;
	logic [mccs_pkg::N_W:0]     r_sub;
	logic                       ge;

	// one restoring step
	always_comb begin
		r_sh  = {r_q, a_q[mccs_pkg::WIN_W-1]};
		ge    = r_sh >= {1'b0, d_q};
		r_sub = r_sh - {1'b0, d_q};
	end

	// control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q + 6'd1;
			busy_q <= (cnt_q != steps_q - 6'd1);
			done_q <= (cnt_q == steps_q - 6'd1);
		end else begin
			done_q <= 1'b0;
		end
	end

	// operands
	always_ff @(posedge clk) begin
		if (start) begin
			a_q     <= dividend;
			r_q     <= '0;
			d_q     <= divisor;
			steps_q <= steps;
		end else if (busy_q) begin
			a_q <= {a_q[mccs_pkg::WIN_W-2:0], ge};
			r_q <= ge ? r_sub[mccs_pkg::N_W-1:0] : r_sh[mccs_pkg::N_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = a_q;

endmodule

>>> sv/mccs_dp.sv
// Datapath: item capture, ln(N), divisions, square root, UCB1 value,
// scan accumulators and the result register. Depends on mccs_pkg, mccs_div.
`include "mcts_child_scan_ucb1_solver_core_assert.svh"
module mccs_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mccs_pkg::cmd_t                 cmd,
	output mccs_pkg::stat_t                stat,
	input  logic                           cfg_valid,
	input  logic [mccs_pkg::GAIN_W-1:0]    cfg_data,
	input  logic [31:0]                    child_visits,
	input  logic [47:0]                    child_wins,
	input  logic [1:0]                     child_status,
	input  logic [7:0]                     child_depth,
	input  logic [31:0]                    parent_visits,
	input  logic [1:0]                     node_status_in,
	input  logic [7:0]                     node_depth_in,
	input  logic                           empty_node,
	input  logic                           last_child,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [5:0]                     ucb_child,
	output logic [5:0]                     chosen_child,
	output logic [1:0]                     status_out,
	output logic [7:0]                     depth_out
);

	// item registers
	logic [31:0]              n_q;
	logic [47:0]              w_q;
	mccs_pkg::proof_t         st_q;
	logic [7:0]               d_q;
	logic [31:0]              pn_q;
	logic [1:0]               nst_q;
	logic [7:0]               nd_q;
	logic                     empty_q;
	logic                     last_q;
	logic [mccs_pkg::GAIN_W-1:0] gain_q;

	// logarithm
	logic [31:0]              lx_q;
	logic [4:0]               ln_q;
	logic [15:0]              frac_q;
	logic [4:0]               sq_cnt_q;
	logic                     sq_ph_q;
	logic [63:0]              sq_prod_s1;
	logic [32:0]              sq_y;
	logic [mccs_pkg::LOG_W-1:0] log_parent_q;
	logic [37:0]              lp_full;

	// divisions
	logic                     div_start;
	logic [47:0]              div_dividend;
	logic [31:0]              div_divisor;
	logic [5:0]               div_steps;
	logic                     div_done;
	logic [47:0]              div_quo;
	logic                     sel_q_q;
	logic [47:0]              q_q;
	logic [mccs_pkg::T_W-1:0] t_q;

	// square root
	logic [mccs_pkg::SQ_IN_W-1:0] sx_q;
	logic [mccs_pkg::SQ_IN_W-1:0] sres_q;
	logic [mccs_pkg::SQ_IN_W-1:0] sbit_q;
	logic [mccs_pkg::SQ_IN_W-1:0] s_trial;
	logic [4:0]               scnt_q;
	logic                     sbusy_q;
	logic                     sdone_q;
	logic [mccs_pkg::GAIN_W+mccs_pkg::SQ_OUT_W-1:0] u_full;
	logic [mccs_pkg::U_W-1:0] u_q;

	// scan accumulators
	logic [mccs_pkg::CNT_W-1:0] cnt_q;
	logic signed [31:0]       best_val_q;
	logic [5:0]               best_pos_q;
	logic                     f_loss_q;
	logic                     f_allwin_q;
	logic                     f_allproven_q;
	logic [7:0]               loss_min_q;
	logic [7:0]               win_max_q;
	logic [7:0]               draw_min_q;
	logic                     sw_valid_q;
	logic [5:0]               sw_pos_q;
	logic [31:0]              mv_q;
	logic signed [17:0]       mv_rate_q;
	logic                     mv_valid_q;
	logic [5:0]               mv_pos_q;
	logic [7:0]               dl_depth_q;
	logic [5:0]               dl_pos_q;

	// result register
	logic                     out_valid_q;
	logic [5:0]               ucb_q;
	logic [5:0]               chosen_q;
	logic [1:0]               pstat_q;
	logic [7:0]               pdepth_q;

	// child value and move-choice terms
	logic [5:0]               pos;
	logic [48:0]              ucb_sum;
	logic signed [31:0]       ucb_sat;
	logic signed [31:0]       proof_mag;
	logic signed [31:0]       val;
	logic signed [17:0]       rate;
	logic [5:0]               chosen;
	logic [1:0]               pstat;
	logic [7:0]               pdepth;

	// status
	always_comb begin
		stat.empty     = empty_q;
		stat.last      = last_q;
		stat.skip      = cnt_q >= mccs_pkg::CNT_W'(mccs_pkg::MAX_CHILDREN);
		stat.first     = cnt_q == '0;
		stat.x_norm    = lx_q[31];
		stat.sq_done   = sq_cnt_q == mccs_pkg::LOG_SQ_STEPS;
		stat.div_done  = div_done;
		stat.sqrt_done = sdone_q;
		stat.out_free  = !out_valid_q || out_ready;
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= mccs_pkg::GAIN_RESET;
		end else if (cfg_valid) begin
			gain_q <= cfg_data;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q     <= child_visits;
			w_q     <= child_wins;
			st_q    <= mccs_pkg::proof_t'(child_status);
			d_q     <= child_depth;
			pn_q    <= parent_visits;
			nst_q   <= node_status_in;
			nd_q    <= node_depth_in;
			empty_q <= empty_node;
			last_q  <= last_child;
		end
	end

	// ln(N): normalize, then 16 squarings (multiply, then renormalize)
	assign sq_y    = sq_prod_s1[63:31];
	assign lp_full = 38'({ln_q, frac_q}) * 38'(mccs_pkg::LN2_Q16) + 38'd32768;

	always_ff @(posedge clk) begin
		if (cmd.log_init) begin
			lx_q     <= (pn_q == '0) ? 32'd1 : pn_q;
			ln_q     <= 5'd31;
			frac_q   <= '0;
			sq_cnt_q <= '0;
			sq_ph_q  <= 1'b0;
		end else if (cmd.log_norm && !lx_q[31]) begin
			lx_q <= {lx_q[30:0], 1'b0};
			ln_q <= ln_q - 5'd1;
		end else if (cmd.log_sq && !stat.sq_done) begin
			if (!sq_ph_q) begin
				sq_prod_s1 <= 64'(lx_q) * 64'(lx_q);
				sq_ph_q    <= 1'b1;
			end else begin
				lx_q     <= sq_y[32] ? sq_y[32:1] : sq_y[31:0];
				frac_q   <= {frac_q[14:0], sq_y[32]};
				sq_cnt_q <= sq_cnt_q + 5'd1;
				sq_ph_q  <= 1'b0;
			end
		end
		if (cmd.log_fin) begin
			log_parent_q <= lp_full[36:16];
		end
	end

	// shared divider: w / n, then 2 ln(N) / n
	always_comb begin
		div_start   = cmd.div_q_go || cmd.div_t_go;
		div_divisor = (n_q == '0) ? 32'd1 : n_q;
		if (cmd.div_q_go) begin
			div_dividend = w_q;
			div_steps    = mccs_pkg::DIV_Q_STEPS;
		end else begin
			div_dividend = {log_parent_q, 1'b0, (48 - mccs_pkg::T_W)'(0)};
			div_steps    = mccs_pkg::DIV_T_STEPS;
		end
	end

	mccs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.steps    (div_steps),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (div_start) begin
			sel_q_q <= cmd.div_q_go;
		end
		if (div_done && sel_q_q) begin
			q_q <= (n_q == '0) ? 48'd0 : div_quo;
		end
		if (div_done && !sel_q_q) begin
			t_q <= div_quo[mccs_pkg::T_W-1:0];
		end
	end

	// square root of t in Q16.16, one result bit per cycle
	assign s_trial = sres_q + sbit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sbusy_q <= 1'b0;
			sdone_q <= 1'b0;
			scnt_q  <= '0;
		end else if (cmd.sqrt_go) begin
			sbusy_q <= 1'b1;
			sdone_q <= 1'b0;
			scnt_q  <= '0;
		end else if (sbusy_q) begin
			scnt_q  <= scnt_q + 5'd1;
			sbusy_q <= (scnt_q != 5'(mccs_pkg::SQ_STEPS - 1));
			sdone_q <= (scnt_q == 5'(mccs_pkg::SQ_STEPS - 1));
		end else begin
			sdone_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sqrt_go) begin
			sx_q   <= {t_q, 16'h0000};
			sres_q <= '0;
			sbit_q <= mccs_pkg::SQ_BIT0;
		end else if (sbusy_q) begin
			if (sx_q >= s_trial) begin
				sx_q   <= sx_q - s_trial;
				sres_q <= (sres_q >> 1) + sbit_q;
			end else begin
				sres_q <= sres_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
		end
	end

	// exploration term
	assign u_full = (mccs_pkg::GAIN_W + mccs_pkg::SQ_OUT_W)'(gain_q)
		* (mccs_pkg::GAIN_W + mccs_pkg::SQ_OUT_W)'(sres_q[mccs_pkg::SQ_OUT_W-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.mul_u) begin
			u_q <= u_full[mccs_pkg::GAIN_W+mccs_pkg::SQ_OUT_W-1:8];
		end
	end

	// child value and win rate
	always_comb begin
		pos       = cnt_q[5:0];
		ucb_sum   = {1'b0, q_q} + 49'(u_q);
		ucb_sat   = (ucb_sum > 49'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(ucb_sum[31:0]);
		proof_mag = signed'({2'b00, mccs_pkg::PROOF_BASE - {6'd0, d_q}, 16'h0000});
		case (st_q)
			mccs_pkg::PROOF_LOSS: val = proof_mag;
			mccs_pkg::PROOF_WIN:  val = -proof_mag;
			default:              val = ucb_sat;
		endcase
		rate = (|q_q[47:17]) ? mccs_pkg::RATE_MAX : signed'({1'b0, q_q[16:0]});
	end

	// node result from the accumulators
	always_comb begin
		if (sw_valid_q) begin
			chosen = sw_pos_q;
		end else if (mv_valid_q) begin
			chosen = mv_pos_q;
		end else begin
			chosen = dl_pos_q;
		end
		if (f_loss_q) begin
			pstat  = mccs_pkg::PROOF_WIN;
			pdepth = mccs_pkg::depth_inc(loss_min_q);
		end else if (f_allwin_q) begin
			pstat  = mccs_pkg::PROOF_LOSS;
			pdepth = mccs_pkg::depth_inc(win_max_q);
		end else if (f_allproven_q) begin
			pstat  = mccs_pkg::PROOF_DRAW;
			pdepth = mccs_pkg::depth_inc(draw_min_q);
		end else begin
			pstat  = nst_q;
			pdepth = nd_q;
		end
	end

	// scan accumulators; cleared after every result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			best_val_q    <= 32'sh8000_0000;
			best_pos_q    <= '0;
			f_loss_q      <= 1'b0;
			f_allwin_q    <= 1'b1;
			f_allproven_q <= 1'b1;
			loss_min_q    <= 8'd255;
			win_max_q     <= '0;
			draw_min_q    <= 8'd255;
			sw_valid_q    <= 1'b0;
			sw_pos_q      <= '0;
			mv_q          <= '0;
			mv_rate_q     <= mccs_pkg::RATE_NONE;
			mv_valid_q    <= 1'b0;
			mv_pos_q      <= '0;
			dl_depth_q    <= '0;
			dl_pos_q      <= '0;
		end else if (cmd.emit_node || cmd.emit_empty) begin
			cnt_q         <= '0;
			best_val_q    <= 32'sh8000_0000;
			best_pos_q    <= '0;
			f_loss_q      <= 1'b0;
			f_allwin_q    <= 1'b1;
			f_allproven_q <= 1'b1;
			loss_min_q    <= 8'd255;
			win_max_q     <= '0;
			draw_min_q    <= 8'd255;
			sw_valid_q    <= 1'b0;
			sw_pos_q      <= '0;
			mv_q          <= '0;
			mv_rate_q     <= mccs_pkg::RATE_NONE;
			mv_valid_q    <= 1'b0;
			mv_pos_q      <= '0;
			dl_depth_q    <= '0;
			dl_pos_q      <= '0;
		end else if (cmd.update) begin
			if (val > best_val_q) begin
				best_val_q <= val;
				best_pos_q <= pos;
			end
			if (st_q == mccs_pkg::PROOF_LOSS) begin
				f_loss_q <= 1'b1;
				if (d_q < loss_min_q) begin
					loss_min_q <= d_q;
					sw_valid_q <= 1'b1;
					sw_pos_q   <= pos;
				end
			end
			if (st_q != mccs_pkg::PROOF_WIN) begin
				f_allwin_q <= 1'b0;
			end else if (d_q > win_max_q) begin
				win_max_q <= d_q;
			end
			if (st_q == mccs_pkg::PROOF_UNKNOWN) begin
				f_allproven_q <= 1'b0;
			end
			if (st_q == mccs_pkg::PROOF_DRAW && d_q < draw_min_q) begin
				draw_min_q <= d_q;
			end
			if (st_q != mccs_pkg::PROOF_WIN
				&& (n_q > mv_q || (n_q == mv_q && rate > mv_rate_q))) begin
				mv_q       <= n_q;
				mv_rate_q  <= rate;
				mv_valid_q <= 1'b1;
				mv_pos_q   <= pos;
			end
			if (d_q >= dl_depth_q) begin
				dl_depth_q <= d_q;
				dl_pos_q   <= pos;
			end
			cnt_q <= cnt_q + mccs_pkg::CNT_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_node || cmd.emit_empty) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_empty) begin
			ucb_q    <= '0;
			chosen_q <= '0;
			pstat_q  <= mccs_pkg::PROOF_LOSS;
			pdepth_q <= '0;
		end else if (cmd.emit_node) begin
			ucb_q    <= best_pos_q;
			chosen_q <= chosen;
			pstat_q  <= pstat;
			pdepth_q <= pdepth;
		end
	end

	assign out_valid    = out_valid_q;
	assign ucb_child    = ucb_q;
	assign chosen_child = chosen_q;
	assign status_out   = pstat_q;
	assign depth_out    = pdepth_q;

	`MCCS_ASSERT_NOW(a_cnt_range, 1'b1,
		cnt_q <= mccs_pkg::CNT_W'(mccs_pkg::MAX_CHILDREN), "child count past limit")
	`MCCS_ASSERT_NOW(a_log_norm, cmd.log_sq, lx_q[31], "log mantissa lost normalization")
	`MCCS_ASSERT_NOW(a_out_src, $rose(out_valid_q),
		$past(cmd.emit_node || cmd.emit_empty), "result appeared without emit")

endmodule

>>> sv/mccs_ctrl.sv
// Controller state machine sequencing the per-child work and the result.
// Depends on mccs_pkg; drives mccs_dp through cmd_t, reads stat_t.
`include "mcts_child_scan_ucb1_solver_core_assert.svh"
module mccs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mccs_pkg::stat_t   stat,
	output mccs_pkg::cmd_t    cmd
);

	mccs_pkg::ctrl_state_t state_q;
	mccs_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mccs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mccs_pkg::S_IDLE: begin
				if (in_valid) state_d = mccs_pkg::S_CHECK;
			end
			mccs_pkg::S_CHECK: begin
				if (stat.empty) begin
					state_d = mccs_pkg::S_EMIT_EMPTY;
				end else if (stat.skip) begin
					state_d = stat.last ? mccs_pkg::S_EMIT : mccs_pkg::S_IDLE;
				end else if (stat.first) begin
					state_d = mccs_pkg::S_LOG_INIT;
				end else begin
					state_d = mccs_pkg::S_DIV_Q_GO;
				end
			end
			mccs_pkg::S_LOG_INIT: state_d = mccs_pkg::S_LOG_NORM;
			mccs_pkg::S_LOG_NORM: begin
				if (stat.x_norm) state_d = mccs_pkg::S_LOG_SQ;
			end
			mccs_pkg::S_LOG_SQ: begin
				if (stat.sq_done) state_d = mccs_pkg::S_LOG_FIN;
			end
			mccs_pkg::S_LOG_FIN:  state_d = mccs_pkg::S_DIV_Q_GO;
			mccs_pkg::S_DIV_Q_GO: state_d = mccs_pkg::S_DIV_Q_WAIT;
			mccs_pkg::S_DIV_Q_WAIT: begin
				if (stat.div_done) state_d = mccs_pkg::S_DIV_T_GO;
			end
			mccs_pkg::S_DIV_T_GO: state_d = mccs_pkg::S_DIV_T_WAIT;
			mccs_pkg::S_DIV_T_WAIT: begin
				if (stat.div_done) state_d = mccs_pkg::S_SQRT_GO;
			end
			mccs_pkg::S_SQRT_GO: state_d = mccs_pkg::S_SQRT_WAIT;
			mccs_pkg::S_SQRT_WAIT: begin
				if (stat.sqrt_done) state_d = mccs_pkg::S_MUL_U;
			end
			mccs_pkg::S_MUL_U: state_d = mccs_pkg::S_UPDATE;
			mccs_pkg::S_UPDATE: begin
				state_d = stat.last ? mccs_pkg::S_EMIT : mccs_pkg::S_IDLE;
			end
			mccs_pkg::S_EMIT, mccs_pkg::S_EMIT_EMPTY: begin
				if (stat.out_free) state_d = mccs_pkg::S_IDLE;
			end
			default: state_d = mccs_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			mccs_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			mccs_pkg::S_LOG_INIT:   cmd.log_init   = 1'b1;
			mccs_pkg::S_LOG_NORM:   cmd.log_norm   = 1'b1;
			mccs_pkg::S_LOG_SQ:     cmd.log_sq     = 1'b1;
			mccs_pkg::S_LOG_FIN:    cmd.log_fin    = 1'b1;
			mccs_pkg::S_DIV_Q_GO:   cmd.div_q_go   = 1'b1;
			mccs_pkg::S_DIV_T_GO:   cmd.div_t_go   = 1'b1;
			mccs_pkg::S_SQRT_GO:    cmd.sqrt_go    = 1'b1;
			mccs_pkg::S_MUL_U:      cmd.mul_u      = 1'b1;
			mccs_pkg::S_UPDATE:     cmd.update     = 1'b1;
			mccs_pkg::S_EMIT:       cmd.emit_node  = stat.out_free;
			mccs_pkg::S_EMIT_EMPTY: cmd.emit_empty = stat.out_free;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

	`MCCS_ASSERT_NOW(a_emit_free, cmd.emit_node || cmd.emit_empty, stat.out_free,
		"result overwritten while pending")
	`MCCS_ASSERT_NEXT(a_load_check, cmd.load, state_q == mccs_pkg::S_CHECK,
		"beat accepted but not checked")
	`MCCS_ASSERT_NOW(a_update_ok, cmd.update, !stat.skip && !stat.empty,
		"update on a skipped or empty beat")

endmodule

>>> sv/mcts_child_scan_ucb1_solver_core.sv
// Top level of the child scan core: UCB1 selection, robust move choice and
// solver proof for one node per scan. Depends on mccs_pkg, mccs_ctrl, mccs_dp.
//
// Usage:
//  - Input channel (in_valid/in_ready): one beat per child record of a node;
//    the beat with last_child set closes the node. A beat with empty_node
//    set closes a node with no children (loss at depth 0).
//  - Output channel (out_valid/out_ready): one beat per closed node with
//    ucb_child, chosen_child, status_out and depth_out.
//  - Config channel (cfg_valid/cfg_ready/cfg_data): exploration gain,
//    Q8.8, reset 362; always ready, write only while the core is idle.
//  - Sequencing: one child at a time. A child's time is set by the
//    shared 1-bit-per-cycle divider (48 steps for w/n, 22 for ln/n)
//    and the 19-step square root. A node's first child adds the ln(N)
//    work: up to 31 normalize shifts and 16 squarings, each a multiply
//    and a renormalize. Skipped children past the limit are not computed.
//  - Results are held in an output register; while it is stalled the core
//    keeps scanning the next node and waits only when that node closes.
//  - Reset clears the scan state, drops any pending result, and restores
//    the gain.
module mcts_child_scan_ucb1_solver_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] child_visits,
	input  logic [47:0] child_wins,
	input  logic [1:0]  child_status,
	input  logic [7:0]  child_depth,
	input  logic [31:0] parent_visits,
	input  logic [1:0]  node_status_in,
	input  logic [7:0]  node_depth_in,
	input  logic        empty_node,
	input  logic        last_child,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  ucb_child,
	output logic [5:0]  chosen_child,
	output logic [1:0]  status_out,
	output logic [7:0]  depth_out
);

	mccs_pkg::cmd_t  cmd;
	mccs_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	mccs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mccs_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.child_visits   (child_visits),
		.child_wins     (child_wins),
		.child_status   (child_status),
		.child_depth    (child_depth),
		.parent_visits  (parent_visits),
		.node_status_in (node_status_in),
		.node_depth_in  (node_depth_in),
		.empty_node     (empty_node),
		.last_child     (last_child),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.ucb_child      (ucb_child),
		.chosen_child   (chosen_child),
		.status_out     (status_out),
		.depth_out      (depth_out)
	);

endmodule
